### rtl/tonp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_pkg
// Shared types and byte codes for the telnet option negotiation parser.
// ----------------------------------------------------------------------------
package tonp_pkg;

	localparam logic [7:0] BYTE_IAC  = 8'd255;
	localparam logic [7:0] BYTE_DONT = 8'd254;
	localparam logic [7:0] BYTE_DO   = 8'd253;
	localparam logic [7:0] BYTE_WONT = 8'd252;
	localparam logic [7:0] BYTE_WILL = 8'd251;
	localparam logic [7:0] BYTE_SB   = 8'd250;
	localparam logic [7:0] BYTE_SE   = 8'd240;
	localparam logic [7:0] BYTE_CR   = 8'd13;
	localparam logic [7:0] BYTE_LF   = 8'd10;

	localparam logic [7:0] CODE_BINARY = 8'd0;
	localparam logic [7:0] CODE_GMCP   = 8'd201;

	localparam int LEN_W = 13;

	typedef enum logic [3:0] {
		PH_DATA,
		PH_IAC,
		PH_WILL,
		PH_WONT,
		PH_DO,
		PH_DONT,
		PH_SB,
		PH_SBDATA,
		PH_SBIAC
	} phase_t;

	typedef enum logic [1:0] {
		LE_NONE,
		LE_CR,
		LE_LF
	} line_end_t;

	typedef enum logic [2:0] {
		KIND_DATA,
		KIND_REPLY,
		KIND_SUB_BYTE,
		KIND_SUB_END,
		KIND_SUB_ABORT
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         value;
		logic [7:0]         reply_verb;
		logic [LEN_W-1:0]   subneg_length;
		logic               subneg_overflow;
		logic               gmcp_accepted;
	} result_t;

endpackage

### rtl/tonp_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_in_stage
// Input register: holds one received byte until the parser consumes it.
// ----------------------------------------------------------------------------
module tonp_in_stage import tonp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // rx_byte
	input  logic       advance,
	output logic       item_valid_s1,
	output logic [7:0] item_byte_s1
);

	assign s_tready = !item_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_byte_s1 <= s_tdata;
		end
	end

endmodule

### rtl/tonp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_parser
// Parse state machine: one byte per step, gives at most one result word.
// ----------------------------------------------------------------------------
module tonp_parser import tonp_pkg::*; #(
	parameter int SUBNEG_LIMIT = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  logic [7:0] custom_option_code,
	output logic       res_valid,
	output result_t    res
);

	localparam int CW = $clog2(SUBNEG_LIMIT + 1);
	localparam logic [CW-1:0] LIMIT_C = CW'(SUBNEG_LIMIT);

	phase_t          phase_q, phase_d;
	line_end_t       le_q, le_d;
	logic [CW-1:0]   cnt_q, cnt_d;
	logic            ovf_q, ovf_d;

	logic            is_cr, is_lf, is_eol, pair_end;
	logic            room;
	line_end_t       le_mine, le_other;
	logic [31:0]     cnt_ext;
	logic [7:0]      will_verb;

	assign is_cr    = (rx_byte == BYTE_CR);
	assign is_lf    = (rx_byte == BYTE_LF);
	assign is_eol   = is_cr || is_lf;
	assign le_mine  = is_cr ? LE_CR : LE_LF;
	assign le_other = is_cr ? LE_LF : LE_CR;
	assign pair_end = is_eol && (le_q == le_other);
	assign room     = (cnt_q < LIMIT_C);
	assign cnt_ext  = 32'(cnt_q);
	assign will_verb = (rx_byte == CODE_BINARY || rx_byte == CODE_GMCP ||
		rx_byte == custom_option_code) ? BYTE_DO : BYTE_DONT;

	// next state
	always_comb begin
		phase_d = phase_q;
		le_d    = le_q;
		cnt_d   = cnt_q;
		ovf_d   = ovf_q;
		unique case (phase_q)
			PH_IAC: begin
				unique case (rx_byte)
					BYTE_WILL: phase_d = PH_WILL;
					BYTE_WONT: phase_d = PH_WONT;
					BYTE_DO:   phase_d = PH_DO;
					BYTE_DONT: phase_d = PH_DONT;
					BYTE_SB:   phase_d = PH_SB;
					default:   phase_d = PH_DATA;
				endcase
			end
			PH_WILL, PH_WONT, PH_DO, PH_DONT: begin
				phase_d = PH_DATA;
			end
			PH_SB: begin
				cnt_d   = '0;
				ovf_d   = 1'b0;
				phase_d = PH_SBDATA;
			end
			PH_SBDATA: begin
				if (rx_byte == BYTE_IAC) begin
					phase_d = PH_SBIAC;
				end else if (room) begin
					cnt_d = cnt_q + 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
			end
			PH_SBIAC: begin
				if (rx_byte == BYTE_IAC) begin
					phase_d = PH_SBDATA;
					if (room) begin
						cnt_d = cnt_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
				end else begin
					cnt_d   = '0;
					ovf_d   = 1'b0;
					phase_d = PH_DATA;
				end
			end
			default: begin
				phase_d = PH_DATA;
				if (is_eol) begin
					le_d = pair_end ? LE_NONE : le_mine;
				end else begin
					le_d = LE_NONE;
					if (rx_byte == BYTE_IAC) begin
						phase_d = PH_IAC;
					end
				end
			end
		endcase
	end

	// result word
	always_comb begin
		res_valid           = 1'b0;
		res.kind            = KIND_DATA;
		res.value           = rx_byte;
		res.reply_verb      = '0;
		res.subneg_length   = '0;
		res.subneg_overflow = 1'b0;
		res.gmcp_accepted   = 1'b0;
		unique case (phase_q)
			PH_IAC: begin
				res_valid = (rx_byte == BYTE_IAC);
			end
			PH_WILL: begin
				res_valid         = 1'b1;
				res.kind          = KIND_REPLY;
				res.reply_verb    = will_verb;
				res.gmcp_accepted = (rx_byte == CODE_GMCP);
			end
			PH_WONT: begin
				res_valid      = 1'b1;
				res.kind       = KIND_REPLY;
				res.reply_verb = (rx_byte == custom_option_code) ? BYTE_DO : BYTE_DONT;
			end
			PH_DO, PH_DONT: begin
				res_valid      = 1'b1;
				res.kind       = KIND_REPLY;
				res.reply_verb = BYTE_WONT;
			end
			PH_SB: begin
				res_valid = 1'b0;
			end
			PH_SBDATA: begin
				res_valid = (rx_byte != BYTE_IAC) && room;
				res.kind  = KIND_SUB_BYTE;
			end
			PH_SBIAC: begin
				if (rx_byte == BYTE_IAC) begin
					res_valid = room;
					res.kind  = KIND_SUB_BYTE;
				end else begin
					res_valid           = 1'b1;
					res.kind            = (rx_byte == BYTE_SE) ? KIND_SUB_END : KIND_SUB_ABORT;
					res.value           = '0;
					res.subneg_length   = cnt_ext[LEN_W-1:0];
					res.subneg_overflow = ovf_q;
				end
			end
			default: begin
				if (is_eol) begin
					res_valid = !pair_end;
					res.value = BYTE_LF;
				end else begin
					res_valid = (rx_byte != BYTE_IAC);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DATA;
			le_q    <= LE_NONE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			le_q    <= le_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

endmodule

### rtl/tonp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tonp_out_reg
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module tonp_out_reg import tonp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_t     res,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // value, reply_verb, subneg_length, subneg_overflow,
	                                // gmcp_accepted, zero pad
	output logic [2:0]  m_tuser     // kind
);

	result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_tuser = res_q.kind;
	assign m_tdata = {1'b0, res_q.gmcp_accepted, res_q.subneg_overflow,
		res_q.subneg_length, res_q.reply_verb, res_q.value};

endmodule

### rtl/telnet_option_negotiation_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_option_negotiation_parser_unit
// Telnet receive parser: strips IAC sequences, folds line ends to LF,
// answers option negotiation commands and streams subnegotiation payload.
//
// Input stream s_*: one received byte per word in s_tdata[7:0].
// Output stream m_*: one result word; m_tuser carries the kind (data byte,
// negotiation reply, subnegotiation byte, end, abort), m_tdata the value,
// reply verb, subnegotiation length, overflow and GMCP flags.
// Bytes that produce nothing (command prefixes, dropped pairs) give no word.
// cfg_we/cfg_wdata write the custom option code; write only while idle.
// Throughput is one byte per cycle unless the result register stalls: the
// parse step is one small decode between the input register and the result
// register; each byte is registered on input and again as its result.
// When the receiver stalls the result register holds its word and the input
// register still takes one more byte; bytes without a result keep flowing.
// Asynchronous reset returns the parser to the data phase, clears the line
// end memory, subnegotiation count and flag, and the custom code to 0.
// ----------------------------------------------------------------------------
module telnet_option_negotiation_parser_unit import tonp_pkg::*; #(
	parameter int SUBNEG_LIMIT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // value, reply_verb, subneg_length, subneg_overflow,
	                                // gmcp_accepted, zero pad
	output logic [2:0]  m_tuser,    // kind
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata
);

	logic       item_valid_s1;
	logic [7:0] item_byte_s1;
	logic       advance;
	logic       res_valid;
	result_t    res;
	logic [7:0] custom_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			custom_code_q <= '0;
		end else if (cfg_we) begin
			custom_code_q <= cfg_wdata;
		end
	end

	assign advance = item_valid_s1 && (!m_tvalid || m_tready || !res_valid);

	tonp_in_stage u_in (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_byte_s1  (item_byte_s1)
	);

	tonp_parser #(
		.SUBNEG_LIMIT (SUBNEG_LIMIT)
	) u_parser (
		.clk                (clk),
		.arst_n             (arst_n),
		.step               (advance),
		.rx_byte            (item_byte_s1),
		.custom_option_code (custom_code_q),
		.res_valid          (res_valid),
		.res                (res)
	);

	tonp_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res_valid),
		.res      (res),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// a held byte is never lost while the parser is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid_s1 && !advance |=> item_valid_s1 && $stable(item_byte_s1))
		else $error("input stage dropped a byte while blocked");

	// only replies carry a verb or the gmcp flag
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != KIND_REPLY) |-> (m_tdata[15:8] == 8'd0) && !m_tdata[30])
		else $error("verb or gmcp flag on a non-reply word");

	// gmcp acceptance is always a DO reply for option GMCP
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[30] |->
			(m_tuser == KIND_REPLY) && (m_tdata[7:0] == CODE_GMCP) &&
			(m_tdata[15:8] == BYTE_DO))
		else $error("gmcp flag on a wrong reply");

	// a completed result word is never overwritten while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !(advance && res_valid))
		else $error("result register loaded while stalled");

endmodule
